// ----- rtl/core/lino_pkg.sv -----
`default_nettype none

package lino_pkg;

  localparam int STEP_W = 4;

  // Micro-operations of the datapath.
  typedef logic [2:0] op_t;
  localparam op_t OP_NOP       = 3'd0;
  localparam op_t OP_CAPTURE   = 3'd1;
  localparam op_t OP_LOAD_LEN  = 3'd2;
  localparam op_t OP_DIV_STEP  = 3'd3;
  localparam op_t OP_SET_LEN   = 3'd4;
  localparam op_t OP_ABS       = 3'd5;
  localparam op_t OP_SET_SLOPE = 3'd6;
  localparam op_t OP_EMIT      = 3'd7;

  // Branch conditions tested by the sequencer.
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NONE       = 3'd0;
  localparam cond_t COND_IN_IDLE    = 3'd1;
  localparam cond_t COND_SEG_ACTIVE = 3'd2;
  localparam cond_t COND_DIV_MORE   = 3'd3;
  localparam cond_t COND_OUT_BUSY   = 3'd4;

  // Configuration register indexes.
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FREQ_SOURCE  = 2'd0;
  localparam reg_idx_t REG_FREQ_SETTING = 2'd1;
  localparam reg_idx_t REG_SAMPLE_RATE  = 2'd2;

  localparam logic [31:0] FREQ_SETTING_RST = 32'd512000;
  localparam logic [17:0] SAMPLE_RATE_RST  = 18'd44100;

  // With wait_c set, a true condition holds the step and blocks its operation,
  // and a false one moves to target. Otherwise a true condition jumps to
  // target and a false one falls through to the next step.
  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic              wait_c;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } dp_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic seg_active;
    logic div_more;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic        freq_source;
    logic [31:0] freq_setting;
    logic [17:0] sample_rate;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/lino_urom.sv -----
`default_nettype none

module lino_urom
  import lino_pkg::*;
(
  input  logic [STEP_W-1:0] addr,
  output uword_t            word
);

  localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LEN_DIV   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SLOPE_DIV = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd8;

  always_comb begin
    case (addr)
      4'd0:    word = '{OP_CAPTURE,   COND_IN_IDLE,    1'b1, STEP_CHECK};
      4'd1:    word = '{OP_NOP,       COND_SEG_ACTIVE, 1'b0, STEP_EMIT};
      4'd2:    word = '{OP_LOAD_LEN,  COND_NONE,       1'b0, STEP_IDLE};
      4'd3:    word = '{OP_DIV_STEP,  COND_DIV_MORE,   1'b0, STEP_LEN_DIV};
      4'd4:    word = '{OP_SET_LEN,   COND_NONE,       1'b0, STEP_IDLE};
      4'd5:    word = '{OP_ABS,       COND_NONE,       1'b0, STEP_IDLE};
      4'd6:    word = '{OP_DIV_STEP,  COND_DIV_MORE,   1'b0, STEP_SLOPE_DIV};
      4'd7:    word = '{OP_SET_SLOPE, COND_NONE,       1'b0, STEP_IDLE};
      4'd8:    word = '{OP_EMIT,      COND_OUT_BUSY,   1'b1, STEP_IDLE};
      default: word = '{OP_NOP,       COND_NONE,       1'b1, STEP_IDLE};
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/lino_seq.sv -----
`default_nettype none

module lino_seq
  import lino_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  logic [STEP_W-1:0] pc_r, pc_nxt;
  uword_t            word;
  logic              cond;

  lino_urom u_urom (
    .addr (pc_r),
    .word (word)
  );

  always_comb begin
    case (word.cond)
      COND_NONE:       cond = 1'b0;
      COND_IN_IDLE:    cond = !stat.in_valid;
      COND_SEG_ACTIVE: cond = stat.seg_active;
      COND_DIV_MORE:   cond = stat.div_more;
      COND_OUT_BUSY:   cond = stat.out_busy;
      default:         cond = 1'b0;
    endcase
  end

  always_comb begin
    if (word.wait_c) begin
      pc_nxt = cond ? pc_r : word.target;
    end else begin
      pc_nxt = cond ? word.target : pc_r + 1'b1;
    end
    ctl.op   = word.op;
    ctl.fire = !(word.wait_c && cond);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lino_dp.sv -----
`default_nettype none

module lino_dp
  import lino_pkg::*;
#(
  parameter int OUT_WIDTH = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_ctl_t              ctl,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  logic [15:0]          in_random_value,
  input  logic [31:0]          in_freq_in,
  input  logic                 out_ready,
  output dp_stat_t             stat,
  output logic                 out_valid,
  output logic [OUT_WIDTH-1:0] out_sample
);

  localparam int SH = 57 - OUT_WIDTH;

  logic [15:0]          rv_r, rv_nxt;
  logic [31:0]          fin_r, fin_nxt;
  logic [63:0]          level_r, level_nxt;
  logic [63:0]          slope_r, slope_nxt;
  logic [31:0]          left_r, left_nxt;
  logic [63:0]          dvd_r, dvd_nxt;
  logic [31:0]          dvs_r, dvs_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_WIDTH-1:0] out_data_r, out_data_nxt;

  logic [31:0]          freq;
  logic [32:0]          trial;
  logic [32:0]          trial_sub;
  logic                 ge;
  logic [31:0]          len;
  logic [63:0]          target;
  logic [63:0]          neg_dvd;
  logic [63:0]          shv;
  logic                 ovf;
  logic [OUT_WIDTH-1:0] sat;

  always_comb begin
    freq      = cfg.freq_source ? fin_r : cfg.freq_setting;
    // One restoring division step: shift in the next dividend bit.
    trial     = {rem_r, dvd_r[63]};
    trial_sub = trial - {1'b0, dvs_r};
    ge        = trial >= {1'b0, dvs_r};
    len       = (dvd_r == 64'd0) ? 32'd1 : dvd_r[31:0];
    target    = {{7{rv_r[15]}}, rv_r, 41'd0};
    neg_dvd   = 64'd0 - dvd_r;

    // Truncate to the output format, then clamp if the dropped high bits
    // are not all copies of the sign.
    shv = 64'($signed(level_r) >>> SH);
    ovf = !((&shv[63:OUT_WIDTH-1]) || !(|shv[63:OUT_WIDTH-1]));
    sat = shv[63] ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : {1'b0, {(OUT_WIDTH-1){1'b1}}};
  end

  always_comb begin
    rv_nxt        = rv_r;
    fin_nxt       = fin_r;
    level_nxt     = level_r;
    slope_nxt     = slope_r;
    left_nxt      = left_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (ctl.fire) begin
      case (ctl.op)
        OP_CAPTURE: begin
          rv_nxt  = in_random_value;
          fin_nxt = in_freq_in;
        end
        OP_LOAD_LEN: begin
          dvd_nxt = {36'd0, cfg.sample_rate, 10'd0};
          dvs_nxt = (freq == 32'd0) ? 32'd1 : freq;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
        OP_DIV_STEP: begin
          rem_nxt = ge ? trial_sub[31:0] : trial[31:0];
          dvd_nxt = {dvd_r[62:0], ge};
          cnt_nxt = cnt_r + 1'b1;
        end
        OP_SET_LEN: begin
          left_nxt = len;
          dvs_nxt  = len;
          dvd_nxt  = target - level_r;
          neg_nxt  = target[63] ^ level_r[63] ^ (target - level_r) >> 63 == 64'd1;
          rem_nxt  = '0;
          cnt_nxt  = '0;
        end
        OP_ABS: begin
          neg_nxt = dvd_r[63];
          dvd_nxt = dvd_r[63] ? neg_dvd : dvd_r;
        end
        OP_SET_SLOPE: begin
          slope_nxt = neg_r ? neg_dvd : dvd_r;
        end
        OP_EMIT: begin
          out_data_nxt  = ovf ? sat : shv[OUT_WIDTH-1:0];
          out_valid_nxt = 1'b1;
          level_nxt     = level_r + slope_r;
          left_nxt      = left_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      slope_r     <= '0;
      left_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      slope_r     <= slope_nxt;
      left_r      <= left_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rv_r       <= rv_nxt;
    fin_r      <= fin_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.in_valid   = in_valid;
  assign stat.seg_active = left_r != 32'd0;
  assign stat.div_more   = cnt_r != 6'd63;
  assign stat.out_busy   = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_sample      = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/linear_interpolated_noise.sv -----
`default_nettype none

// Channel  Direction  Fields (low bit first)
// in_      slave      tdata: random_value[15:0], freq_in[31:0]
// out_     master     tdata: sample[OUT_WIDTH-1:0], zero fill to whole bytes
// cfg_     slave      cfg_index selects the register, cfg_data carries its value
//
// An item inside a segment passes the capture, check and emit steps, and its
// sample is registered at the emit step. An item that opens a segment also
// computes length and slope, and each needs a 64-step restoring division.
// Reset clears the level, the slope and the segment count, loads the register
// defaults and holds both ready outputs low.
// A stalled output holds the emit step; no new input is taken meanwhile.
module linear_interpolated_noise
  import lino_pkg::*;
#(
  parameter int OUT_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [47:0]                        in_tdata,   // random_value, freq_in
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((OUT_WIDTH+7)/8)*8-1:0]     out_tdata,  // sample, zero fill
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int TD_W = ((OUT_WIDTH + 7) / 8) * 8;

  cfg_t                 cfg_r, cfg_nxt;
  dp_ctl_t              ctl;
  dp_stat_t             stat;
  logic [OUT_WIDTH-1:0] sample;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FREQ_SOURCE:  cfg_nxt.freq_source  = cfg_data[0];
        REG_FREQ_SETTING: cfg_nxt.freq_setting = cfg_data;
        REG_SAMPLE_RATE:  cfg_nxt.sample_rate  = cfg_data[17:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{1'b0, FREQ_SETTING_RST, SAMPLE_RATE_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = rst_n;

  lino_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  lino_dp #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_random_value (in_tdata[15:0]),
    .in_freq_in      (in_tdata[47:16]),
    .out_ready       (out_tready),
    .stat            (stat),
    .out_valid       (out_tvalid),
    .out_sample      (sample)
  );

  assign in_tready = rst_n && (ctl.op == OP_CAPTURE);
  assign out_tdata = TD_W'(sample);

  // One item at a time: the sequencer never takes two inputs back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted in consecutive cycles");

  // A sample is only written into a free or draining output register.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && ctl.op == OP_EMIT) |-> !(out_tvalid && !out_tready))
    else $error("sample emitted over a stalled result");

  // A new segment always has at least one sample.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && ctl.op == OP_SET_LEN) |=> stat.seg_active)
    else $error("segment started with zero length");

endmodule

`default_nettype wire
